// File: rtl/fjelp_pkg.sv
`timescale 1ns / 1ps

package fjelp_pkg;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       end_of_line;
	} item_t;

	typedef enum logic [2:0] {
		KIND_KEY_BYTE   = 3'd0,
		KIND_EVENT_BYTE = 3'd1,
		KIND_VALUE_BYTE = 3'd2,
		KIND_STR_DONE   = 3'd3,
		KIND_INT_DONE   = 3'd4,
		KIND_EVENT_DONE = 3'd5,
		KIND_ACCEPT     = 3'd6,
		KIND_REJECT     = 3'd7
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         data_byte;
		logic signed [63:0] int_value;
		logic [2:0]         slot;
	} result_t;

	typedef enum logic [1:0] {
		STR_KEY   = 2'd0,
		STR_EVENT = 2'd1,
		STR_VALUE = 2'd2
	} str_kind_t;

	typedef enum logic [1:0] {
		EVM_NONE = 2'd0,
		EVM_E    = 2'd1,
		EVM_EV   = 2'd2,
		EVM_DIFF = 2'd3
	} ev_match_t;

	// largest magnitude that may still take another digit: floor((2^63 - d) / 10)
	localparam logic [63:0] ACC_LIM_LOW  = 64'd922337203685477580;  // digits 0..8
	localparam logic [63:0] ACC_LIM_NINE = 64'd922337203685477579;  // digit 9
	localparam logic [63:0] INT_MIN_MAG  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] INT_MAX_POS  = 64'h7fff_ffff_ffff_ffff;

endpackage

// File: rtl/flat_json_event_line_parser_unit.sv
`timescale 1ns / 1ps

// Flat JSON object parser, one line byte per beat. Each accepted item is
// decoded in the same cycle by the parse state machine and its result, if
// any, lands in a single output register; with res_ready held high a new
// byte is taken every cycle, and a stalled result blocks input only while
// the output register stays full. An item produces at most one result:
// key, event or value bytes (after escape expansion and truncation to
// KEY_LEN-1, EVENT_LEN-1, VALUE_LEN-1), field-done markers with the slot
// number, and one accept or reject per line. Integers are saturated to 64
// bits with one shift-add and compare per digit. An end_of_line item forces
// the outcome if it is still pending and returns all state to reset.
module flat_json_event_line_parser_unit #(
	parameter int KEY_LEN    = 32,
	parameter int VALUE_LEN  = 128,
	parameter int MAX_FIELDS = 8,
	parameter int EVENT_LEN  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  fjelp_pkg::item_t   item,
	output logic              res_valid,
	input  logic              res_ready,
	output fjelp_pkg::result_t res
);
	import fjelp_pkg::*;

	localparam int KL_W   = $clog2(KEY_LEN);
	localparam int VL_MAX = (VALUE_LEN > EVENT_LEN) ? VALUE_LEN : EVENT_LEN;
	localparam int VL_W   = $clog2(VL_MAX);
	localparam int FC_W   = $clog2(MAX_FIELDS + 1);

	localparam logic [KL_W-1:0] KEY_LIM = KL_W'(KEY_LEN - 1);
	localparam logic [VL_W-1:0] EV_LIM  = VL_W'(EVENT_LEN - 1);
	localparam logic [VL_W-1:0] VAL_LIM = VL_W'(VALUE_LEN - 1);
	localparam logic [FC_W-1:0] FC_MAX  = FC_W'(MAX_FIELDS);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_VT     = 8'h0b;
	localparam logic [7:0] CH_FF     = 8'h0c;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_B   = 8'h62;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_LO_N   = 8'h6e;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_LO_U   = 8'h75;
	localparam logic [7:0] CH_LO_V   = 8'h76;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;

	typedef enum logic [11:0] {
		M_OPEN        = 12'b0000_0000_0001,
		M_KEYCLOSE    = 12'b0000_0000_0010,
		M_AFTER_KEY   = 12'b0000_0000_0100,
		M_VALUE_START = 12'b0000_0000_1000,
		M_STR         = 12'b0000_0001_0000,
		M_ESC         = 12'b0000_0010_0000,
		M_HEX         = 12'b0000_0100_0000,
		M_INT_WS      = 12'b0000_1000_0000,
		M_INT_BODY    = 12'b0001_0000_0000,
		M_AFTER_VALUE = 12'b0010_0000_0000,
		M_PENDING     = 12'b0100_0000_0000,
		M_DONE        = 12'b1000_0000_0000
	} mode_t;

	mode_t       mode_q, n_mode;
	str_kind_t   str_q, n_str;
	logic [KL_W-1:0] key_len_q, n_key_len;
	ev_match_t   match_q, n_match;
	logic [VL_W-1:0] val_len_q, n_val_len;
	logic [1:0]  hex_cnt_q, n_hex_cnt;
	logic [7:0]  hex_low_q, n_hex_low;
	logic [63:0] acc_q, n_acc;
	logic        neg_q, n_neg;
	logic        seen_q, n_seen;
	logic [FC_W-1:0] fc_q, n_fc;
	logic        have_ev_q, n_have_ev;

	logic        res_valid_q;
	result_t     res_q, r;
	logic        emit;
	logic        accept;

	logic [7:0]  c;
	logic        c_ws, c_cspace, c_digit;
	logic [3:0]  dig;
	logic        live;
	logic [FC_W+2:0] fc_ext;
	logic [2:0]  slot_now;

	logic [7:0]  esc_val;
	logic        esc_ok;
	logic [3:0]  hex_d;
	logic        hex_ok;
	logic [7:0]  sb_byte;
	logic        st_en, id_en, dec_en, dec_acc;
	logic        lead_en, lead_ws_ok;
	logic [63:0] acc10, int_mag;
	logic        acc_sat;

	assign item_ready = !res_valid_q || res_ready;
	assign accept     = item_valid && item_ready;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	assign c        = item.line_byte;
	assign c_ws     = (c == CH_SPACE) || (c == CH_TAB);
	assign c_cspace = c_ws || (c == CH_LF) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
	assign c_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
	assign dig      = c[3:0];
	assign live     = fc_q < FC_MAX;
	assign fc_ext   = {3'b000, fc_q};
	assign slot_now = fc_ext[2:0];

	always_comb begin
		esc_ok  = 1'b1;
		esc_val = c;
		case (c)
			CH_QUOTE:  esc_val = CH_QUOTE;
			CH_BSLASH: esc_val = CH_BSLASH;
			CH_SLASH:  esc_val = CH_SLASH;
			CH_LO_B:   esc_val = CH_BS;
			CH_LO_F:   esc_val = CH_FF;
			CH_LO_N:   esc_val = CH_LF;
			CH_LO_R:   esc_val = CH_CR;
			CH_LO_T:   esc_val = CH_TAB;
			default:   esc_ok  = 1'b0;
		endcase
	end

	always_comb begin
		hex_ok = 1'b1;
		hex_d  = c[3:0];
		if (c_digit) begin
			hex_d = c[3:0];
		end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
			hex_d = c[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	// saturating decimal step: acc * 10 + d, or the 2^63 magnitude on overflow
	assign acc_sat = acc_q > ((dig == 4'd9) ? ACC_LIM_NINE : ACC_LIM_LOW);
	assign acc10   = (acc_q << 3) + (acc_q << 1) + {60'd0, dig};

	always_comb begin
		if (neg_q) begin
			int_mag = acc_q[63] ? INT_MIN_MAG : (64'd0 - acc_q);
		end else begin
			int_mag = acc_q[63] ? INT_MAX_POS : acc_q;
		end
	end

	always_comb begin
		case (mode_q)
			M_ESC:   sb_byte = esc_val;
			M_HEX:   sb_byte = {hex_low_q[3:0], hex_d};
			default: sb_byte = c;
		endcase
	end

	always_comb begin
		n_mode    = mode_q;
		n_str     = str_q;
		n_key_len = key_len_q;
		n_match   = match_q;
		n_val_len = val_len_q;
		n_hex_cnt = hex_cnt_q;
		n_hex_low = hex_low_q;
		n_acc     = acc_q;
		n_neg     = neg_q;
		n_seen    = seen_q;
		n_fc      = fc_q;
		n_have_ev = have_ev_q;

		emit        = 1'b0;
		r.kind      = KIND_KEY_BYTE;
		r.data_byte = 8'd0;
		r.int_value = 64'sd0;
		r.slot      = 3'd0;

		st_en      = 1'b0;
		id_en      = 1'b0;
		dec_en     = 1'b0;
		dec_acc    = 1'b0;
		lead_en    = 1'b0;
		lead_ws_ok = 1'b0;

		if (item.end_of_line) begin
			if (mode_q != M_DONE) begin
				emit   = 1'b1;
				r.kind = (mode_q == M_PENDING && have_ev_q) ? KIND_ACCEPT : KIND_REJECT;
			end
			n_mode    = M_OPEN;
			n_str     = STR_KEY;
			n_key_len = '0;
			n_match   = EVM_NONE;
			n_val_len = '0;
			n_hex_cnt = 2'd0;
			n_hex_low = 8'd0;
			n_acc     = 64'd0;
			n_neg     = 1'b0;
			n_seen    = 1'b0;
			n_fc      = '0;
			n_have_ev = 1'b0;
		end else begin
			case (mode_q)
				M_DONE: begin
				end
				M_PENDING: begin
					dec_en  = 1'b1;
					dec_acc = have_ev_q;
				end
				M_OPEN: begin
					if (c == CH_LBRACE) begin
						n_mode = M_KEYCLOSE;
					end else if (!c_ws) begin
						dec_en = 1'b1;
					end
				end
				M_KEYCLOSE: begin
					if (c == CH_RBRACE) begin
						dec_en  = 1'b1;
						dec_acc = have_ev_q;
					end else if (c == CH_QUOTE) begin
						n_key_len = '0;
						n_match   = EVM_NONE;
						n_str     = STR_KEY;
						n_mode    = M_STR;
					end else if (!c_ws) begin
						dec_en = 1'b1;
					end
				end
				M_AFTER_KEY: begin
					if (c == CH_COLON) begin
						n_mode = M_VALUE_START;
					end else if (!c_ws) begin
						dec_en = 1'b1;
					end
				end
				M_VALUE_START: begin
					if (c == CH_QUOTE) begin
						n_val_len = '0;
						n_str     = (match_q == EVM_EV) ? STR_EVENT : STR_VALUE;
						n_mode    = M_STR;
					end else if (!c_ws) begin
						if (match_q == EVM_EV) begin
							dec_en = 1'b1;
						end else begin
							n_acc      = 64'd0;
							n_neg      = 1'b0;
							n_seen     = 1'b0;
							n_mode     = M_INT_WS;
							lead_en    = 1'b1;
							lead_ws_ok = 1'b1;
						end
					end
				end
				M_INT_WS: begin
					lead_en    = 1'b1;
					lead_ws_ok = 1'b1;
				end
				M_INT_BODY: begin
					if (!seen_q) begin
						lead_en = 1'b1;
					end else if (c_digit) begin
						n_acc = acc_sat ? INT_MIN_MAG : acc10;
					end else if (c_ws) begin
						n_mode = M_AFTER_VALUE;
						id_en  = 1'b1;
					end else if (c == CH_COMMA) begin
						n_mode = M_KEYCLOSE;
						id_en  = 1'b1;
					end else if (c == CH_RBRACE) begin
						if (!live) begin
							dec_en  = 1'b1;
							dec_acc = have_ev_q;
						end else begin
							n_mode = M_PENDING;
							id_en  = 1'b1;
						end
					end else begin
						dec_en = 1'b1;
					end
				end
				M_AFTER_VALUE: begin
					if (c == CH_COMMA) begin
						n_mode = M_KEYCLOSE;
					end else if (c == CH_RBRACE) begin
						dec_en  = 1'b1;
						dec_acc = have_ev_q;
					end else if (!c_ws) begin
						dec_en = 1'b1;
					end
				end
				M_STR: begin
					if (c == CH_NUL) begin
						dec_en = 1'b1;
					end else if (c == CH_QUOTE) begin
						case (str_q)
							STR_KEY: begin
								n_mode = M_AFTER_KEY;
							end
							STR_EVENT: begin
								n_mode    = M_AFTER_VALUE;
								n_have_ev = 1'b1;
								emit      = 1'b1;
								r.kind    = KIND_EVENT_DONE;
							end
							default: begin
								n_mode = M_AFTER_VALUE;
								if (live) begin
									n_fc   = fc_q + 1'b1;
									emit   = 1'b1;
									r.kind = KIND_STR_DONE;
									r.slot = slot_now;
								end
							end
						endcase
					end else if (c == CH_BSLASH) begin
						n_mode = M_ESC;
					end else begin
						st_en = 1'b1;
					end
				end
				M_ESC: begin
					if (c == CH_LO_U) begin
						n_hex_cnt = 2'd0;
						n_hex_low = 8'd0;
						n_mode    = M_HEX;
					end else if (esc_ok) begin
						n_mode = M_STR;
						st_en  = 1'b1;
					end else begin
						dec_en = 1'b1;
					end
				end
				M_HEX: begin
					if (!hex_ok) begin
						dec_en = 1'b1;
					end else begin
						n_hex_low = sb_byte;
						n_hex_cnt = hex_cnt_q + 2'd1;
						if (hex_cnt_q == 2'd3) begin
							n_mode = M_STR;
							st_en  = 1'b1;
						end
					end
				end
				default: begin
					dec_en = 1'b1;
				end
			endcase
		end

		// text ahead of the first digit: white space, one sign, then a digit
		if (lead_en) begin
			if (lead_ws_ok && c_cspace) begin
				n_mode = M_INT_WS;
			end else if (lead_ws_ok && (c == CH_PLUS || c == CH_MINUS)) begin
				n_neg  = (c == CH_MINUS);
				n_mode = M_INT_BODY;
			end else if (c_digit) begin
				n_acc  = {60'd0, dig};
				n_seen = 1'b1;
				n_mode = M_INT_BODY;
			end else begin
				dec_en = 1'b1;
			end
		end

		if (st_en) begin
			case (str_q)
				STR_KEY: begin
					if (key_len_q < KEY_LIM) begin
						if (sb_byte == CH_NUL) begin
							n_key_len = KEY_LIM;
						end else begin
							if (key_len_q == '0) begin
								n_match = (sb_byte == CH_LO_E) ? EVM_E : EVM_DIFF;
							end else if (key_len_q == KL_W'(1)) begin
								n_match = (match_q == EVM_E && sb_byte == CH_LO_V) ?
									EVM_EV : EVM_DIFF;
							end else begin
								n_match = EVM_DIFF;
							end
							n_key_len = key_len_q + 1'b1;
							if (live) begin
								emit        = 1'b1;
								r.kind      = KIND_KEY_BYTE;
								r.data_byte = sb_byte;
								r.slot      = slot_now;
							end
						end
					end
				end
				STR_EVENT: begin
					if (val_len_q < EV_LIM) begin
						if (sb_byte == CH_NUL) begin
							n_val_len = EV_LIM;
						end else begin
							n_val_len   = val_len_q + 1'b1;
							emit        = 1'b1;
							r.kind      = KIND_EVENT_BYTE;
							r.data_byte = sb_byte;
						end
					end
				end
				default: begin
					if (val_len_q < VAL_LIM) begin
						if (sb_byte == CH_NUL) begin
							n_val_len = VAL_LIM;
						end else begin
							n_val_len = val_len_q + 1'b1;
							if (live) begin
								emit        = 1'b1;
								r.kind      = KIND_VALUE_BYTE;
								r.data_byte = sb_byte;
								r.slot      = slot_now;
							end
						end
					end
				end
			endcase
		end

		if (id_en && live) begin
			n_fc        = fc_q + 1'b1;
			emit        = 1'b1;
			r.kind      = KIND_INT_DONE;
			r.int_value = $signed(int_mag);
			r.slot      = slot_now;
		end

		if (dec_en) begin
			n_mode      = M_DONE;
			emit        = 1'b1;
			r.kind      = dec_acc ? KIND_ACCEPT : KIND_REJECT;
			r.data_byte = 8'd0;
			r.int_value = 64'sd0;
			r.slot      = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_OPEN;
			str_q       <= STR_KEY;
			key_len_q   <= '0;
			match_q     <= EVM_NONE;
			val_len_q   <= '0;
			hex_cnt_q   <= 2'd0;
			hex_low_q   <= 8'd0;
			acc_q       <= 64'd0;
			neg_q       <= 1'b0;
			seen_q      <= 1'b0;
			fc_q        <= '0;
			have_ev_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q    <= n_mode;
				str_q     <= n_str;
				key_len_q <= n_key_len;
				match_q   <= n_match;
				val_len_q <= n_val_len;
				hex_cnt_q <= n_hex_cnt;
				hex_low_q <= n_hex_low;
				acc_q     <= n_acc;
				neg_q     <= n_neg;
				seen_q    <= n_seen;
				fc_q      <= n_fc;
				have_ev_q <= n_have_ev;
			end
			if (accept && emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_q <= r;
		end
	end

endmodule
